// ----- hdl/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, types and tables of the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int TICK_BITS_DEF = 12;
  localparam int POS_BITS_DEF  = 48;
  localparam int TRIG_BITS_DEF = 16;
  localparam int GYRO_BITS     = 16;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ANG_W     = 32;
  // q30 values of the series stay below 2^31
  localparam int Q_W       = 31;
  localparam int DEN_W     = 7;
  localparam int MUL_BW    = 32;

  localparam logic [31:0] PIQ30 = 32'd3373259426;

  localparam logic [CFG_IDX_W-1:0] REG_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd3;

  localparam logic [31:0] DIST_RST = 32'd662150;
  localparam logic [31:0] HEAD_RST = 32'd353050;
  localparam logic [31:0] GYRO_RST = 32'd6836;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_M, ST_MUL_D, ST_HEAD, ST_MUL_PHI, ST_MUL_X2, ST_MUL_T,
    ST_DIV_T, ST_ACC_T, ST_SC_X, ST_ADD_X, ST_SC_Y, ST_ADD_Y, ST_OUT
  } ddo_state_e;

  // taylor term divisors: sin uses (2k+2)(2k+3), cos uses (2k+1)(2k+2)
  function automatic logic [DEN_W-1:0] taylor_div(input logic cos_sel,
                                                  input logic [2:0] k);
    logic [DEN_W-1:0] v;
    v = 7'd1;
    unique case ({cos_sel, k})
      4'b0_000: v = 7'd6;
      4'b0_001: v = 7'd20;
      4'b0_010: v = 7'd42;
      4'b0_011: v = 7'd72;
      4'b0_100: v = 7'd110;
      4'b1_000: v = 7'd2;
      4'b1_001: v = 7'd12;
      4'b1_010: v = 7'd30;
      4'b1_011: v = 7'd56;
      4'b1_100: v = 7'd90;
      default:  v = 7'd1;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ddo_mul.sv -----
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; #(
  parameter int AW = 45,
  parameter int BW = MUL_BW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] a_sh_q;
  logic [PW-1:0] acc_q;
  logic [BW-1:0] b_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_sh_q <= PW'(a_i);
      b_q    <= b_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_sh_q;
      end
      a_sh_q <= {a_sh_q[PW-2:0], 1'b0};
      b_q    <= {1'b0, b_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- hdl/ddo_div.sv -----
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider, one quotient bit per cycle, for the series divisors.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; #(
  parameter int NW = Q_W,
  parameter int DW = DEN_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits in DW bits
      rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
      num_q <= {num_q[NW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hdl/diff_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning pose integrator for a differential-drive robot.
// ----------------------------------------------------------------------------
// One sample is taken at a time. The cost is set by a bit-serial multiplier
// (32-bit multiplier operand), shared by all products, and a bit-serial
// divider used for the series: six products for distance, heading, angle
// scaling, the squared angle and the two axis steps, and ten multiply-divide
// pairs of the sine and cosine series. The result sits in an output register
// so the next sample is accepted while the previous result waits.
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF,
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [TICK_BITS-1:0] right_ticks_i,
  input  logic signed [TICK_BITS-1:0] left_ticks_i,
  input  logic signed [GYRO_BITS-1:0] gyro_rate_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          pos_x_o,
  output logic signed [31:0]          pos_y_o,
  output logic signed [15:0]          heading_out_o,
  output logic                        pos_saturated_o
);

  localparam int SUM_W  = TICK_BITS + 1;
  localparam int AW     = 32 + SUM_W;
  localparam int PW     = AW + MUL_BW;
  localparam int UT_W   = TRIG_BITS + 1;
  localparam int TSHIFT = 30 - TRIG_BITS;
  localparam int EW     = ((POS_BITS > AW) ? POS_BITS : AW) + 2;
  localparam logic signed [EW-1:0] PMAX =
    $signed({{(EW-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}});
  localparam logic signed [EW-1:0] PMIN = -PMAX - EW'(1);

  ddo_state_e state_q, state_d;

  // configuration
  logic [31:0] dist_q, head_q, gyro_q;
  logic        mode_q;

  // sample and working registers
  logic signed [TICK_BITS-1:0] rt_q, lt_q;
  logic signed [GYRO_BITS-1:0] gr_q;
  logic [AW-1:0]    m_mag_q;
  logic             m_neg_q;
  logic [32:0]      d_q;
  logic [ANG_W-1:0] ang_q;
  logic [Q_W-1:0]   x2_q, t_q, tt_q;
  logic signed [32:0] ser_q, s_q;
  logic [2:0]       k_q;
  logic             cos_sel_q;
  logic [UT_W-1:0]  ux_q, uy_q;
  logic             xneg_q, yneg_q;
  logic [AW-1:0]    res_q;
  logic             launched_q;
  logic             sat_q;

  // state
  logic signed [POS_BITS-1:0] x_acc_q, y_acc_q;
  logic [ANG_W-1:0]           heading_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [15:0]        head_out_q;
  logic               pos_sat_q;

  // serial units
  logic            mul_start, mul_done;
  logic [AW-1:0]   mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PW-1:0]   mul_p;
  logic            div_start, div_done;
  logic [Q_W-1:0]  div_q;

  logic signed [SUM_W-1:0] sum, diff;
  logic [SUM_W-1:0]        sum_abs, diff_abs;
  logic [GYRO_BITS:0]      gr_abs;
  logic [29:0]             r_red;
  logic [32:0]             d_new;
  logic signed [32:0]      ser_d;
  logic [UT_W-1:0]         s_rnd, c_rnd;
  logic [PW-1:0]           p_rnd;
  logic signed [EW-1:0]    add_sum;
  logic signed [POS_BITS-1:0] add_res;
  logic                    add_sat;
  logic [32:0]             ox, oy;
  logic                    in_acc, out_load;

  function automatic logic [UT_W-1:0] trig_round(input logic signed [32:0] v);
    logic [31:0] pos;
    pos = v[32] ? 32'd0 : v[31:0];
    pos = pos + (32'd1 << (TSHIFT - 1));
    return pos[30:TSHIFT];
  endfunction

  // floor by 2^16 then clamp to 32 bits; top bit flags the clamp
  function automatic logic [32:0] out_pos(input logic signed [POS_BITS-1:0] a);
    logic signed [63:0] sh;
    logic [32:0] r;
    sh = 64'(a) >>> 16;
    if (sh > 64'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (sh < -64'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, sh[31:0]};
    end
    return r;
  endfunction

  assign sum      = SUM_W'(rt_q) + SUM_W'(lt_q);
  assign diff     = SUM_W'(rt_q) - SUM_W'(lt_q);
  assign sum_abs  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign diff_abs = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
  assign gr_abs   = gr_q[GYRO_BITS-1] ? (GYRO_BITS+1)'(-(GYRO_BITS+1)'(gr_q))
                                      : (GYRO_BITS+1)'(gr_q);
  // octant folding: odd octants mirror the angle
  assign r_red    = ang_q[29] ? (30'h20000000 - {1'b0, ang_q[28:0]})
                              : {1'b0, ang_q[28:0]};
  assign d_new    = (mode_q ? gr_q[GYRO_BITS-1] : diff[SUM_W-1]) ? (33'd0 - mul_p[32:0])
                                                                 : mul_p[32:0];
  assign ser_d    = k_q[0] ? (ser_q + 33'(t_q)) : (ser_q - 33'(t_q));
  assign s_rnd    = trig_round(s_q);
  assign c_rnd    = trig_round(ser_d);
  assign p_rnd    = mul_p + PW'(1 << TRIG_BITS);

  always_comb begin
    logic signed [EW-1:0] delta;
    logic signed [POS_BITS-1:0] acc;
    acc     = (state_q == ST_ADD_X) ? x_acc_q : y_acc_q;
    delta   = ((state_q == ST_ADD_X) ? xneg_q : yneg_q) ? -EW'(res_q) : EW'(res_q);
    add_sum = EW'(acc) + delta;
    add_sat = 1'b0;
    add_res = add_sum[POS_BITS-1:0];
    if (add_sum > PMAX) begin
      add_res = PMAX[POS_BITS-1:0];
      add_sat = 1'b1;
    end else if (add_sum < PMIN) begin
      add_res = PMIN[POS_BITS-1:0];
      add_sat = 1'b1;
    end
  end

  assign ox = out_pos(x_acc_q);
  assign oy = out_pos(y_acc_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_MUL_M;
      ST_MUL_M:   if (mul_done) state_d = ST_MUL_D;
      ST_MUL_D:   if (mul_done) state_d = ST_HEAD;
      ST_HEAD:    state_d = ST_MUL_PHI;
      ST_MUL_PHI: if (mul_done) state_d = ST_MUL_X2;
      ST_MUL_X2:  if (mul_done) state_d = ST_MUL_T;
      ST_MUL_T:   if (mul_done) state_d = ST_DIV_T;
      ST_DIV_T:   if (div_done) state_d = ST_ACC_T;
      ST_ACC_T: begin
        if (k_q == 3'd4 && cos_sel_q) state_d = ST_SC_X;
        else state_d = ST_MUL_T;
      end
      ST_SC_X:    if (mul_done) state_d = ST_ADD_X;
      ST_ADD_X:   state_d = ST_SC_Y;
      ST_SC_Y:    if (mul_done) state_d = ST_ADD_Y;
      ST_ADD_Y:   state_d = ST_OUT;
      ST_OUT:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_MUL_M: begin
        mul_start = !launched_q;
        mul_a     = AW'(dist_q);
        mul_b     = MUL_BW'(sum_abs);
      end
      ST_MUL_D: begin
        mul_start = !launched_q;
        mul_a     = mode_q ? AW'(gyro_q) : AW'(head_q);
        mul_b     = mode_q ? MUL_BW'(gr_abs) : MUL_BW'(diff_abs);
      end
      ST_MUL_PHI: begin
        mul_start = !launched_q;
        mul_a     = AW'(r_red);
        mul_b     = PIQ30;
      end
      ST_MUL_X2: begin
        mul_start = !launched_q;
        mul_a     = AW'(t_q);
        mul_b     = MUL_BW'(t_q);
      end
      ST_MUL_T: begin
        mul_start = !launched_q;
        mul_a     = AW'(t_q);
        mul_b     = MUL_BW'(x2_q);
      end
      ST_DIV_T: div_start = !launched_q;
      ST_SC_X: begin
        mul_start = !launched_q;
        mul_a     = m_mag_q;
        mul_b     = MUL_BW'(ux_q);
      end
      ST_SC_Y: begin
        mul_start = !launched_q;
        mul_a     = m_mag_q;
        mul_b     = MUL_BW'(uy_q);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  ddo_mul #(.AW(AW), .BW(MUL_BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  ddo_div #(.NW(Q_W), .DW(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tt_q),
    .den_i   (taylor_div(cos_sel_q, k_q)),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // control, configuration and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dist_q      <= DIST_RST;
      head_q      <= HEAD_RST;
      gyro_q      <= GYRO_RST;
      mode_q      <= 1'b0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      heading_q   <= '0;
      k_q         <= '0;
      cos_sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_done || div_done) begin
        launched_q <= 1'b0;
      end else if (mul_start || div_start) begin
        launched_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DIST: dist_q <= cfg_data_i;
          REG_HEAD: head_q <= cfg_data_i;
          REG_GYRO: gyro_q <= cfg_data_i;
          REG_MODE: mode_q <= cfg_data_i[0];
          default:  mode_q <= mode_q;
        endcase
      end
      if (state_q == ST_HEAD) begin
        heading_q <= heading_q + d_q[31:0];
      end
      if (state_q == ST_ADD_X) x_acc_q <= add_res;
      if (state_q == ST_ADD_Y) y_acc_q <= add_res;
      if (state_q == ST_MUL_PHI && mul_done) begin
        k_q       <= '0;
        cos_sel_q <= 1'b0;
      end
      if (state_q == ST_ACC_T) begin
        if (k_q == 3'd4) begin
          k_q       <= '0;
          cos_sel_q <= 1'b1;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rt_q  <= right_ticks_i;
      lt_q  <= left_ticks_i;
      gr_q  <= gyro_rate_i;
      sat_q <= 1'b0;
    end
    if (state_q == ST_MUL_M && mul_done) begin
      m_mag_q <= mul_p[AW-1:0];
      m_neg_q <= sum[SUM_W-1];
    end
    if (state_q == ST_MUL_D && mul_done) begin
      d_q <= d_new;
    end
    if (state_q == ST_HEAD) begin
      // wheel mode trig angle is old heading plus floor of half the increment
      ang_q <= mode_q ? (heading_q + d_q[31:0]) : (heading_q + d_q[32:1]);
    end
    if (state_q == ST_MUL_PHI && mul_done) begin
      t_q   <= mul_p[31+Q_W-1:31];
      ser_q <= 33'(mul_p[31+Q_W-1:31]);
    end
    if (state_q == ST_MUL_X2 && mul_done) begin
      x2_q <= mul_p[30+Q_W-1:30];
    end
    if (state_q == ST_MUL_T && mul_done) begin
      tt_q <= mul_p[30+Q_W-1:30];
    end
    if (state_q == ST_DIV_T && div_done) begin
      t_q <= div_q;
    end
    if (state_q == ST_ACC_T) begin
      if (k_q == 3'd4 && !cos_sel_q) begin
        s_q   <= ser_d;
        t_q   <= Q_W'(1 << 30);
        ser_q <= 33'(1 << 30);
      end else begin
        ser_q <= ser_d;
      end
      if (k_q == 3'd4 && cos_sel_q) begin
        // co takes sine in octants 1,2,5,6; signs from the upper octant bits
        ux_q   <= (ang_q[29] ^ ang_q[30]) ? s_rnd : c_rnd;
        uy_q   <= (ang_q[29] ^ ang_q[30]) ? c_rnd : s_rnd;
        xneg_q <= m_neg_q ^ (ang_q[31] ^ ang_q[30]);
        yneg_q <= m_neg_q ^ ang_q[31];
      end
    end
    if ((state_q == ST_SC_X || state_q == ST_SC_Y) && mul_done) begin
      res_q <= p_rnd[TRIG_BITS+1+AW-1:TRIG_BITS+1];
    end
    if ((state_q == ST_ADD_X || state_q == ST_ADD_Y) && add_sat) begin
      sat_q <= 1'b1;
    end
    if (out_load) begin
      pos_x_q    <= ox[31:0];
      pos_y_q    <= oy[31:0];
      head_out_q <= heading_q[31:16];
      pos_sat_q  <= sat_q | ox[32] | oy[32];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign heading_out_o   = head_out_q;
  assign pos_saturated_o = pos_sat_q;

endmodule
